// ===== src/lzd_pkg.sv =====
// lzd_pkg: shared types and constants of the lzss image decoder
// used by lzd_ctrl, lzd_datapath and the top level; no dependencies
package lzd_pkg;

    localparam int WINDOW_DEPTH   = 4096;
    localparam int WIN_AW         = $clog2(WINDOW_DEPTH);
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int PIX_W      = 8;
    localparam int OUT_ADDR_W = 20;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int LEN_W      = 5;
    localparam int FCNT_W     = 4;

    localparam logic [WIN_AW-1:0] WP_START   = 12'hfee;
    localparam logic [PIX_W-1:0]  INV_MASK   = 8'hff;
    localparam logic [FCNT_W-1:0] FLAGS_FULL = 4'd8;
    localparam logic [LEN_W-1:0]  MIN_MATCH  = 5'd3;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LIT,
        ST_MREAD,
        ST_MEMIT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic begin_img;
        logic set_finished;
        logic load_flags;
        logic load_first;
        logic start_match;
        logic start_lit;
        logic emit;
        logic emit_lit;
        logic emit_last;
        logic step_flags;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cmd_begin;
        logic clear_last;
        logic is_finished;
        logic row_past;
        logic flags_empty;
        logic have_first;
        logic flag_msb;
        logic out_free;
        logic len_one;
        logic done_now;
    } dp_status_t;

endpackage

// ===== src/lzd_ram.sv =====
// lzd_ram: generic single-write, single-read ram with registered read data
// no dependencies
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lzd_ctrl.sv =====
// lzd_ctrl: controller state machine of the lzss image decoder
// depends on lzd_pkg; drives commands into lzd_datapath
module lzd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lzd_pkg::dp_status_t status,
    output lzd_pkg::ctrl_cmd_t  cmd
);
    import lzd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    priority if (status.cmd_begin) begin
                        cmd.begin_img = 1'b1;
                        state_next    = ST_CLEAR;
                    end else if (status.is_finished) begin
                        state_next = ST_IDLE;
                    end else if (status.row_past) begin
                        cmd.set_finished = 1'b1;
                    end else if (status.flags_empty) begin
                        cmd.load_flags = 1'b1;
                    end else if (status.have_first) begin
                        cmd.start_match = 1'b1;
                        state_next      = ST_MREAD;
                    end else if (status.flag_msb) begin
                        cmd.start_lit = 1'b1;
                        state_next    = ST_LIT;
                    end else begin
                        cmd.load_first = 1'b1;
                    end
                end
            end
            ST_LIT: begin
                if (status.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_lit   = 1'b1;
                    cmd.emit_last  = 1'b1;
                    cmd.step_flags = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_MREAD: begin
                state_next = ST_MEMIT;
            end
            ST_MEMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.len_one || status.done_now) begin
                        cmd.emit_last  = 1'b1;
                        cmd.step_flags = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        state_next = ST_MREAD;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/lzd_datapath.sv =====
// lzd_datapath: window ram, flag and match registers, pixel counters,
// address multiplier, output register and configuration registers
// depends on lzd_pkg and lzd_ram; controlled by lzd_ctrl
module lzd_datapath #(
    parameter int MAX_WIDTH  = lzd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lzd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [lzd_pkg::PIX_W-1:0]        s_tdata,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    input  logic [lzd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lzd_pkg::CFG_W-1:0]        cfg_data,
    input  lzd_pkg::ctrl_cmd_t               cmd,
    output lzd_pkg::dp_status_t              status
);
    import lzd_pkg::*;

    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CXW   = WD_W + 1;
    localparam int CWW   = (CFG_W > WD_W) ? CFG_W : WD_W;
    localparam int CHW   = (CFG_W > HT_W) ? CFG_W : HT_W;
    localparam int PW    = WD_W + HT_W + 1;
    localparam int AW    = (PW > OUT_ADDR_W) ? PW : OUT_ADDR_W;

    logic [CFG_W-1:0]  img_width_reg, img_height_reg;
    logic [WIN_AW-1:0] wp_reg, wp_next;
    logic [WIN_AW-1:0] pos_reg, pos_next;
    logic [WIN_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PIX_W-1:0]  flag_bits_reg, flag_bits_next;
    logic [FCNT_W-1:0] flags_left_reg, flags_left_next;
    logic [PIX_W-1:0]  pending_reg, pending_next;
    logic              have_first_reg, have_first_next;
    logic [PIX_W-1:0]  lit_reg, lit_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [HT_W-1:0]   row_reg, row_next;
    logic              finished_reg, finished_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic              m_tuser_reg, m_tuser_next;

    logic [PIX_W-1:0]  in_byte;
    logic [PIX_W-1:0]  ram_rdata;
    logic              ram_we;
    logic [WIN_AW-1:0] ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [PIX_W-1:0]  pix_value;
    logic [CWW-1:0]    w_ext;
    logic [CHW-1:0]    h_ext;
    logic [WD_W-1:0]   w_clamp;
    logic [HT_W-1:0]   h_clamp;
    logic [CXW-1:0]    col_inc;
    logic              col_wrap;
    logic [HT_W-1:0]   row_emit;
    logic              done_now;
    logic [HT_W-1:0]   row_rem;
    logic [AW-1:0]     addr_full;
    logic              out_free;

    assign in_byte = s_tdata ^ INV_MASK;
    assign out_free = !m_tvalid_reg || m_tready;

    // clamp of the image size registers
    always_comb begin
        w_ext = CWW'(img_width_reg);
        h_ext = CHW'(img_height_reg);
        if (w_ext == '0) begin
            w_clamp = WD_W'(1);
        end else if (w_ext > CWW'(MAX_WIDTH)) begin
            w_clamp = WD_W'(MAX_WIDTH);
        end else begin
            w_clamp = WD_W'(w_ext);
        end
        if (h_ext == '0) begin
            h_clamp = HT_W'(1);
        end else if (h_ext > CHW'(MAX_HEIGHT)) begin
            h_clamp = HT_W'(MAX_HEIGHT);
        end else begin
            h_clamp = HT_W'(h_ext);
        end
    end

    // pixel position and flipped address
    always_comb begin
        col_inc   = CXW'(col_reg) + CXW'(1);
        col_wrap  = col_inc >= CXW'(w_clamp);
        row_emit  = col_wrap ? row_reg + HT_W'(1) : row_reg;
        done_now  = row_emit >= h_clamp;
        row_rem   = h_clamp - HT_W'(1) - row_reg;
        addr_full = AW'(col_reg) + AW'(w_clamp) * AW'(row_rem);
    end

    assign pix_value = cmd.emit_lit ? lit_reg : ram_rdata;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = pix_value;
        if (cmd.clear_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (cmd.emit) begin
            ram_we = 1'b1;
        end
    end

    lzd_ram #(
        .WIDTH(PIX_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_window (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(pos_reg),
        .rdata(ram_rdata)
    );

    always_comb begin
        wp_next         = wp_reg;
        pos_next        = pos_reg;
        clr_cnt_next    = clr_cnt_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        pending_next    = pending_reg;
        have_first_next = have_first_reg;
        lit_next        = lit_reg;
        len_next        = len_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        finished_next   = finished_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        m_tuser_next    = m_tuser_reg;

        if (cmd.clear_step) begin
            clr_cnt_next = clr_cnt_reg + WIN_AW'(1);
        end
        if (cmd.begin_img) begin
            wp_next         = WP_START;
            clr_cnt_next    = '0;
            flag_bits_next  = '0;
            flags_left_next = '0;
            pending_next    = '0;
            have_first_next = 1'b0;
            col_next        = '0;
            row_next        = '0;
            finished_next   = 1'b0;
        end
        if (cmd.set_finished) begin
            finished_next = 1'b1;
        end
        if (cmd.load_flags) begin
            flag_bits_next  = in_byte;
            flags_left_next = FLAGS_FULL;
        end
        if (cmd.load_first) begin
            pending_next    = in_byte;
            have_first_next = 1'b1;
        end
        if (cmd.start_match) begin
            have_first_next = 1'b0;
            len_next        = LEN_W'(pending_reg[3:0]) + MIN_MATCH;
            pos_next        = {in_byte, pending_reg[7:4]};
        end
        if (cmd.start_lit) begin
            lit_next = in_byte;
        end
        if (cmd.emit) begin
            wp_next       = wp_reg + WIN_AW'(1);
            col_next      = col_wrap ? '0 : col_inc[COL_W-1:0];
            row_next      = row_emit;
            finished_next = done_now;
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(32 - OUT_ADDR_W - PIX_W){1'b0}},
                             addr_full[OUT_ADDR_W-1:0], pix_value};
            m_tlast_next  = cmd.emit_last;
            m_tuser_next  = done_now;
            if (!cmd.emit_lit) begin
                pos_next = pos_reg + WIN_AW'(1);
                len_next = len_reg - LEN_W'(1);
            end
        end
        if (cmd.step_flags) begin
            flag_bits_next  = {flag_bits_reg[PIX_W-2:0], 1'b0};
            flags_left_next = flags_left_reg - FCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_width_reg  <= CFG_W'(1);
            img_height_reg <= CFG_W'(1);
            wp_reg         <= WP_START;
            clr_cnt_reg    <= '0;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            pending_reg    <= '0;
            have_first_reg <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            finished_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == REG_IMAGE_WIDTH) begin
                img_width_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_IMAGE_HEIGHT) begin
                img_height_reg <= cfg_data;
            end
            wp_reg         <= wp_next;
            clr_cnt_reg    <= clr_cnt_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            pending_reg    <= pending_next;
            have_first_reg <= have_first_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            finished_reg   <= finished_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        lit_reg     <= lit_next;
        len_reg     <= len_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        status             = '0;
        status.cmd_begin   = (s_tuser == CMD_BEGIN);
        status.clear_last  = (clr_cnt_reg == {WIN_AW{1'b1}});
        status.is_finished = finished_reg;
        status.row_past    = row_reg >= h_clamp;
        status.flags_empty = (flags_left_reg == '0);
        status.have_first  = have_first_reg;
        status.flag_msb    = flag_bits_reg[PIX_W-1];
        status.out_free    = out_free;
        status.len_one     = (len_reg == LEN_W'(1));
        status.done_now    = done_now;
    end

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("pixel emitted while output register is occupied");

    a_emit_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid_reg)
        else $error("emitted pixel not presented on the output");

    a_clear_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !cmd.emit)
        else $error("pixel emitted during window clearing");

    a_match_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_match |=> (len_reg >= MIN_MATCH))
        else $error("match length below minimum");

    a_flags_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_left_reg <= FLAGS_FULL)
        else $error("flag count out of range");

endmodule

// ===== src/lzss_image_decoder_unit.sv =====
// lzss_image_decoder_unit: top level of the lzss image decoder
// depends on lzd_pkg, lzd_ctrl, lzd_datapath and lzd_ram
//
// usage:
// - s_ channel: one transfer per compressed byte; s_tuser is the command
//   (0 begins a new image, 1 delivers s_tdata), s_tdata the byte as stored
// - m_ channel: one transfer per decoded pixel; m_tlast marks the last
//   pixel caused by one input byte, m_tuser marks the final image pixel
// - cfg channel: image width (index 0) and height (index 1), cfg_ready is
//   always high; write only while the decoder is idle
// - after reset and after each begin command the 4096-entry window is
//   swept to zero, one entry per cycle with s_tready low
// - a flag byte or a first match byte is handled in idle, a literal also in
//   ST_LIT, a match (length 3 to 18) in ST_MREAD and ST_MEMIT for each pixel;
//   a match pixel costs a window read on the single read port and a write-back
// - output pixels sit in one output register; while the receiver stalls
//   the decoder holds its pixel and stops, no pixel is dropped
// - bytes after the last pixel of the image are accepted and discarded
module lzss_image_decoder_unit #(
    parameter int MAX_WIDTH  = lzd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lzd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lzd_pkg::PIX_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                          s_tuser,   // [0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [7:0] pixel_value, [27:8] pixel_address
    output logic                          m_tlast,
    output logic                          m_tuser,   // [0] image_done
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lzd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lzd_pkg::CFG_W-1:0]     cfg_data
);
    import lzd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    lzd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    lzd_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
